/* hw/rtl/triangle_scanline_span_generator_assert.svh */
// Assertion macros used by the span generator back end.
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define TSSG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define TSSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tssg_pkg.sv */
// Shared types, constants and helper functions of the span generator.
package tssg_pkg;

    // Command codes of the input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Full illumination in units of 1/256.
    localparam logic [8:0] LIGHT_FULL = 9'd256;

    // Number of span jobs that the queue between front and back holds.
    localparam int QUEUE_DEPTH = 2;

    // Fill color of one triangle.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    // Fill level of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // States of the span back end.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_START,
        BK_DIV,
        BK_FIN
    } back_state_t;

    // Width of one packed span job for a given coordinate width.
    function automatic int job_bits(input int coord_bits);
        return 9 * coord_bits + 35;
    endfunction

    // Scales one color channel by a saturated light level, truncating.
    function automatic logic [7:0] shade(input logic [7:0] c, input logic [8:0] l);
        logic [16:0] p;
        p = {9'd0, c} * {8'd0, l};
        return p[15:8];
    endfunction

endpackage

/* hw/rtl/tssg_front.sv */
// Front end: takes commands, sorts and stores triangles, issues span jobs.
module tssg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_write_en,
    input  logic                                          cfg_write_data,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic                                          cmd,
    input  logic signed [COORD_BITS-1:0]                  first_x,
    input  logic signed [COORD_BITS-1:0]                  first_y,
    input  logic signed [COORD_BITS-1:0]                  second_x,
    input  logic signed [COORD_BITS-1:0]                  second_y,
    input  logic signed [COORD_BITS-1:0]                  third_x,
    input  logic signed [COORD_BITS-1:0]                  third_y,
    input  logic [7:0]                                    red,
    input  logic [7:0]                                    green,
    input  logic [7:0]                                    blue,
    input  logic [7:0]                                    alpha,
    input  logic [8:0]                                    light_level,
    input  tssg_pkg::queue_status_t                       q_status,
    output logic                                          q_push,
    output logic [tssg_pkg::job_bits(COORD_BITS)-1:0]     q_data
);
    import tssg_pkg::*;

    localparam int W = COORD_BITS;

    typedef struct packed {
        logic [W-1:0]        row_y;
        logic [W-1:0]        idx_a;
        logic [W-1:0]        den_a;
        logic signed [W:0]   dx_a;
        logic [W-1:0]        base_a;
        logic [W-1:0]        idx_b;
        logic [W-1:0]        den_b;
        logic signed [W:0]   dx_b;
        logic [W-1:0]        base_b;
        color_t              color;
        logic                last;
    } span_job_t;

    logic                lit_enable_reg, lit_enable_next;
    logic signed [W-1:0] vx_reg [3];
    logic signed [W-1:0] vy_reg [3];
    logic signed [W-1:0] vx_next [3];
    logic signed [W-1:0] vy_next [3];
    color_t              color_reg, color_next;
    logic [W-1:0]        row_reg, row_next;
    logic                pending_reg, pending_next;

    logic                accept;
    logic                is_load;
    logic signed [W-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
    logic signed [W-1:0] q0x, q0y, q2x, q2y;
    logic signed [W-1:0] r1x, r1y, r2x, r2y;
    logic [8:0]          light_sat;
    logic [W:0]          total_wide, upper_wide, lower_wide;
    logic                second_part;
    logic                last_step;
    span_job_t           job;

    assign accept   = in_valid && !q_status.full;
    assign in_stall = q_status.full;
    assign is_load  = (cmd == CMD_LOAD);

    // Three compare-and-swap stages order the vertices by ascending y.
    always_comb
    begin
        if (first_y > second_y)
        begin
            p0x = second_x; p0y = second_y; p1x = first_x; p1y = first_y;
        end
        else
        begin
            p0x = first_x; p0y = first_y; p1x = second_x; p1y = second_y;
        end
        p2x = third_x;
        p2y = third_y;
        if (p0y > p2y)
        begin
            q0x = p2x; q0y = p2y; q2x = p0x; q2y = p0y;
        end
        else
        begin
            q0x = p0x; q0y = p0y; q2x = p2x; q2y = p2y;
        end
        if (p1y > q2y)
        begin
            r1x = q2x; r1y = q2y; r2x = p1x; r2y = p1y;
        end
        else
        begin
            r1x = p1x; r1y = p1y; r2x = q2x; r2y = q2y;
        end
    end

    assign light_sat = (light_level > LIGHT_FULL) ? LIGHT_FULL : light_level;

    // Per-row edge setup from the stored triangle.
    assign total_wide  = {vy_reg[2][W-1], vy_reg[2]} - {vy_reg[0][W-1], vy_reg[0]};
    assign upper_wide  = {vy_reg[1][W-1], vy_reg[1]} - {vy_reg[0][W-1], vy_reg[0]};
    assign lower_wide  = {vy_reg[2][W-1], vy_reg[2]} - {vy_reg[1][W-1], vy_reg[1]};
    assign second_part = (row_reg > upper_wide[W-1:0]) || (upper_wide[W-1:0] == '0);
    assign last_step   = (({1'b0, row_reg} + {{W{1'b0}}, 1'b1}) == total_wide);

    always_comb
    begin
        job.row_y  = vy_reg[0] + row_reg;
        job.idx_a  = row_reg;
        job.den_a  = total_wide[W-1:0];
        job.dx_a   = {vx_reg[2][W-1], vx_reg[2]} - {vx_reg[0][W-1], vx_reg[0]};
        job.base_a = vx_reg[0];
        if (second_part)
        begin
            job.idx_b  = row_reg - upper_wide[W-1:0];
            job.den_b  = lower_wide[W-1:0];
            job.dx_b   = {vx_reg[2][W-1], vx_reg[2]} - {vx_reg[1][W-1], vx_reg[1]};
            job.base_b = vx_reg[1];
        end
        else
        begin
            job.idx_b  = row_reg;
            job.den_b  = upper_wide[W-1:0];
            job.dx_b   = {vx_reg[1][W-1], vx_reg[1]} - {vx_reg[0][W-1], vx_reg[0]};
            job.base_b = vx_reg[0];
        end
        job.color = color_reg;
        job.last  = last_step;
    end

    assign q_push = accept && !is_load && pending_reg;
    assign q_data = job;

    // Lighting switch and triangle state update for load and step words.
    always_comb
    begin
        lit_enable_next = cfg_write_en ? cfg_write_data : lit_enable_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        color_next   = color_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (accept && is_load)
        begin
            vx_next[0] = q0x; vy_next[0] = q0y;
            vx_next[1] = r1x; vy_next[1] = r1y;
            vx_next[2] = r2x; vy_next[2] = r2y;
            color_next.red   = lit_enable_reg ? shade(red, light_sat) : red;
            color_next.green = lit_enable_reg ? shade(green, light_sat) : green;
            color_next.blue  = lit_enable_reg ? shade(blue, light_sat) : blue;
            color_next.alpha = alpha;
            row_next     = '0;
            pending_next = (r2y > q0y);
        end
        else if (q_push)
        begin
            row_next = row_reg + {{(W-1){1'b0}}, 1'b1};
            if (last_step)
            begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_enable_reg <= 1'b0;
            vx_reg         <= '{default: '0};
            vy_reg         <= '{default: '0};
            color_reg      <= '0;
            row_reg        <= '0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            lit_enable_reg <= lit_enable_next;
            vx_reg         <= vx_next;
            vy_reg         <= vy_next;
            color_reg      <= color_next;
            row_reg        <= row_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

/* hw/rtl/tssg_queue.sv */
// Short job queue between the front end and the span back end.
module tssg_queue #(
    parameter int WIDTH = 143
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        pop_data,
    output tssg_pkg::queue_status_t status
);
    import tssg_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [PTR_BITS:0]   FULL_COUNT = (PTR_BITS + 1)'(QUEUE_DEPTH);

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/tssg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module tssg_div #(
    parameter int WIDTH = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*WIDTH-1:0]   num,
    input  logic [WIDTH-1:0]     den,
    output logic                 busy,
    output logic [WIDTH-1:0]     quo
);
    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    lo_reg, lo_next;
    logic [WIDTH-1:0]    den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      diff;
    logic                fits;

    // The upper half of the dividend is below the divisor, so WIDTH steps
    // give the whole quotient.
    assign shifted = {rem_reg, lo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign busy    = (cnt_reg != '0);
    assign quo     = (den_reg == '0) ? '0 : lo_reg;

    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = num[2*WIDTH-1:WIDTH];
            lo_next  = num[WIDTH-1:0];
            cnt_next = CNT_BITS'(WIDTH);
        end
        else if (busy)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            lo_next  = {lo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

endmodule

/* hw/rtl/tssg_back.sv */
// Back end: interpolates both span edges of one row and drives the output word.
module tssg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  tssg_pkg::queue_status_t                   q_status,
    output logic                                      q_pop,
    input  logic [tssg_pkg::job_bits(COORD_BITS)-1:0] q_data,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [COORD_BITS-1:0]              row_y,
    output logic signed [COORD_BITS-1:0]              span_left,
    output logic signed [COORD_BITS-1:0]              span_right,
    output logic [7:0]                                out_red,
    output logic [7:0]                                out_green,
    output logic [7:0]                                out_blue,
    output logic [7:0]                                out_alpha,
    output logic                                      last_row
);
    import tssg_pkg::*;

    `include "triangle_scanline_span_generator_assert.svh"

    localparam int W = COORD_BITS;

    typedef struct packed {
        logic [W-1:0]        row_y;
        logic [W-1:0]        idx_a;
        logic [W-1:0]        den_a;
        logic signed [W:0]   dx_a;
        logic [W-1:0]        base_a;
        logic [W-1:0]        idx_b;
        logic [W-1:0]        den_b;
        logic signed [W:0]   dx_b;
        logic [W-1:0]        base_b;
        color_t              color;
        logic                last;
    } span_job_t;

    back_state_t         state_reg, state_next;
    span_job_t           job_reg;
    logic [2*W-1:0]      prod_a_reg, prod_b_reg;
    logic                neg_a_reg, neg_b_reg;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        row_y_reg;
    logic signed [W-1:0] left_reg, right_reg;
    color_t              color_reg;
    logic                last_reg;

    logic                div_start;
    logic                out_load;
    logic                out_free;
    logic                busy_a, busy_b;
    logic [W-1:0]        quo_a, quo_b;
    logic [W:0]          mag_a_wide, mag_b_wide;
    logic signed [W:0]   qa, qb;
    logic signed [W+1:0] ax, bx;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_START;
            end
            BK_START:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (!busy_a)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE:  q_pop     = !q_status.empty;
            BK_START: div_start = 1'b1;
            BK_FIN:   out_load  = out_free;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Edge magnitudes for the unsigned multiply and divide.
    assign mag_a_wide = job_reg.dx_a[W] ? -job_reg.dx_a : job_reg.dx_a;
    assign mag_b_wide = job_reg.dx_b[W] ? -job_reg.dx_b : job_reg.dx_b;

    tssg_div #(.WIDTH(W)) u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_a_reg),
        .den   (job_reg.den_a),
        .busy  (busy_a),
        .quo   (quo_a)
    );

    tssg_div #(.WIDTH(W)) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_b_reg),
        .den   (job_reg.den_b),
        .busy  (busy_b),
        .quo   (quo_b)
    );

    // Signed quotients truncate toward zero; each edge x lies between its ends.
    assign qa = neg_a_reg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
    assign qb = neg_b_reg ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});
    assign ax = $signed({{2{job_reg.base_a[W-1]}}, job_reg.base_a}) + $signed({qa[W], qa});
    assign bx = $signed({{2{job_reg.base_b[W-1]}}, job_reg.base_b}) + $signed({qb[W], qb});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job, product and output registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (state_reg == BK_MUL)
        begin
            prod_a_reg <= {{W{1'b0}}, job_reg.idx_a} * {{W{1'b0}}, mag_a_wide[W-1:0]};
            prod_b_reg <= {{W{1'b0}}, job_reg.idx_b} * {{W{1'b0}}, mag_b_wide[W-1:0]};
            neg_a_reg  <= job_reg.dx_a[W];
            neg_b_reg  <= job_reg.dx_b[W];
        end
        if (out_load)
        begin
            row_y_reg <= job_reg.row_y;
            left_reg  <= (ax < bx) ? ax[W-1:0] : bx[W-1:0];
            right_reg <= (ax < bx) ? bx[W-1:0] : ax[W-1:0];
            color_reg <= job_reg.color;
            last_reg  <= job_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_y      = row_y_reg;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign out_red    = color_reg.red;
    assign out_green  = color_reg.green;
    assign out_blue   = color_reg.blue;
    assign out_alpha  = color_reg.alpha;
    assign last_row   = last_reg;

    // Both dividers run the same schedule.
    `TSSG_ASSERT_SAME(a_div_lockstep, state_reg == BK_DIV, busy_a == busy_b,
        "edge dividers out of step")
    // A start always leaves the divider busy.
    `TSSG_ASSERT_NEXT(a_div_started, state_reg == BK_START, busy_a && busy_b,
        "divider did not take its start")
    // A new output word only comes from the finishing state.
    `TSSG_ASSERT_SAME(a_out_from_fin, $rose(out_valid_reg), $past(state_reg == BK_FIN),
        "output word appeared outside the finishing state")
    // A finished span waits while the receiver holds the previous word.
    `TSSG_ASSERT_NEXT(a_fin_waits, state_reg == BK_FIN && out_valid_reg && out_stall,
        state_reg == BK_FIN, "span left the back end while output was stalled")

endmodule

/* hw/rtl/triangle_scanline_span_generator.sv */
// Top level of the triangle scanline span generator.
//
// Input channel (in_valid / in_stall): a word with cmd at load takes three
// vertices, a color and a light level; it gives no result.
// A word with cmd at step asks for the span of the next row of the loaded
// triangle and gives one output word, or none when no triangle is pending.
// Output channel (out_valid / out_stall): row_y, span_left, span_right, the
// shaded color and last_row, which marks the bottom span of the triangle.
// The lighting switch is written through cfg_write_en / cfg_write_data and is
// sampled when a triangle loads.
// A step's span passes through the job queue and the back end's idle, multiply,
// start, divide and finish states before it appears. The back end works on one
// span at a time, paced by the two bit-serial edge dividers, which run side by
// side; a two-entry job queue lets the front take words meanwhile.
// Reset leaves no triangle pending, lighting off and the queue empty.
// While out_stall is high the output word holds, the back end waits with the
// next span, the queue fills and then in_stall rises.
module triangle_scanline_span_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic                         cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    input  logic signed [COORD_BITS-1:0] third_x,
    input  logic signed [COORD_BITS-1:0] third_y,
    input  logic [7:0]                   red,
    input  logic [7:0]                   green,
    input  logic [7:0]                   blue,
    input  logic [7:0]                   alpha,
    input  logic [8:0]                   light_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] row_y,
    output logic signed [COORD_BITS-1:0] span_left,
    output logic signed [COORD_BITS-1:0] span_right,
    output logic [7:0]                   out_red,
    output logic [7:0]                   out_green,
    output logic [7:0]                   out_blue,
    output logic [7:0]                   out_alpha,
    output logic                         last_row
);
    import tssg_pkg::*;

    localparam int JOB_BITS = job_bits(COORD_BITS);

    logic                q_push;
    logic                q_pop;
    logic [JOB_BITS-1:0] push_data;
    logic [JOB_BITS-1:0] pop_data;
    queue_status_t       q_status;

    tssg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .third_x        (third_x),
        .third_y        (third_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .light_level    (light_level),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_data         (push_data)
    );

    tssg_queue #(.WIDTH(JOB_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    tssg_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .q_data     (pop_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_y      (row_y),
        .span_left  (span_left),
        .span_right (span_right),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .last_row   (last_row)
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the triangle scanline span generator.
module tb_top;
    import tssg_pkg::*;

    localparam int COORD = 12;
    // Idle cycles allowed after the last expected span before a register write
    // or the end of the run, well past the step-to-span latency.
    localparam int SETTLE = 3 * (COORD + 5) + 32;
    // Cycles without any word taken on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 4000;

    // One input word as the driver sees it.
    typedef struct packed {
        logic             cmd;
        logic [COORD-1:0] ax;
        logic [COORD-1:0] ay;
        logic [COORD-1:0] bx;
        logic [COORD-1:0] by;
        logic [COORD-1:0] cx;
        logic [COORD-1:0] cy;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [8:0]       light;
    } tri_word_t;

    // One output word: a filled row span and its color.
    typedef struct packed {
        logic [COORD-1:0] row;
        logic [COORD-1:0] lo_x;
        logic [COORD-1:0] hi_x;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last;
    } span_t;

    // How a stimulus row gets its expected span.
    typedef enum {CHK_MODEL, CHK_SPAN, CHK_NONE} check_kind_t;

    typedef struct {
        bit          lit;
        tri_word_t   w;
        check_kind_t kind;
        span_t       want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic cfg_write_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = CMD_STEP;
    logic signed [COORD-1:0] first_x = '0;
    logic signed [COORD-1:0] first_y = '0;
    logic signed [COORD-1:0] second_x = '0;
    logic signed [COORD-1:0] second_y = '0;
    logic signed [COORD-1:0] third_x = '0;
    logic signed [COORD-1:0] third_y = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic [7:0] alpha = '0;
    logic [8:0] light_level = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [COORD-1:0] row_y;
    logic signed [COORD-1:0] span_left;
    logic signed [COORD-1:0] span_right;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic last_row;

    // Shadow copy of the block's state, kept by the span predictor.
    int         vx [3];
    int         vy [3];
    int         row_idx = 0;
    bit         tri_live = 1'b0;
    logic [7:0] fill [4] = '{default: 8'd0};
    bit         lit_on = 1'b0;

    span_t    spans_due [$];
    dir_row_t dir_rows [$];
    bit       gaps_on = 1'b1;
    int       errors = 0;
    int       n_loads = 0;
    int       n_steps = 0;
    int       n_checked = 0;
    int       n_cfg = 0;
    int       idle_cycles = 0;

    triangle_scanline_span_generator #(.COORD_BITS(COORD)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .first_x(first_x), .first_y(first_y),
        .second_x(second_x), .second_y(second_y),
        .third_x(third_x), .third_y(third_y),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .light_level(light_level),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_y(row_y), .span_left(span_left), .span_right(span_right),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .last_row(last_row)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Appends one row to the directed stimulus table.
    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic tri_word_t tri_load(input int ax, input int ay, input int bx,
                                           input int by, input int cx, input int cy,
                                           input int r, input int g, input int b,
                                           input int a, input int l);
        tri_word_t w;
        w.cmd = CMD_LOAD;
        w.ax = COORD'(ax);
        w.ay = COORD'(ay);
        w.bx = COORD'(bx);
        w.by = COORD'(by);
        w.cx = COORD'(cx);
        w.cy = COORD'(cy);
        w.red = 8'(r);
        w.green = 8'(g);
        w.blue = 8'(b);
        w.alpha = 8'(a);
        w.light = 9'(l);
        return w;
    endfunction

    function automatic tri_word_t step_word();
        tri_word_t w;
        w = '0;
        w.cmd = CMD_STEP;
        return w;
    endfunction

    function automatic span_t span_of(input int row, input int lo, input int hi,
                                      input int r, input int g, input int b,
                                      input int a, input bit last);
        span_t s;
        s.row = COORD'(row);
        s.lo_x = COORD'(lo);
        s.hi_x = COORD'(hi);
        s.red = 8'(r);
        s.green = 8'(g);
        s.blue = 8'(b);
        s.alpha = 8'(a);
        s.last = last;
        return s;
    endfunction

    function automatic string span_text(input span_t s);
        return $sformatf("row %0d x %0d..%0d rgba %0d/%0d/%0d/%0d last %0d",
                         $signed(s.row), $signed(s.lo_x), $signed(s.hi_x),
                         s.red, s.green, s.blue, s.alpha, s.last);
    endfunction

    function automatic void swap_vertex(input int a, input int b);
        int t;
        t = vx[a];
        vx[a] = vx[b];
        vx[b] = t;
        t = vy[a];
        vy[a] = vy[b];
        vy[b] = t;
    endfunction

    // Span predictor: updates the shadow state for one taken word and
    // returns 1 with the span when the word yields one.
    function automatic bit raster_word(input tri_word_t w, output span_t s);
        int lvl, total, upper, seg, off, i, ax, bx;
        bit lower;
        s = '0;
        if (w.cmd == CMD_LOAD)
        begin
            vx[0] = $signed(w.ax);
            vy[0] = $signed(w.ay);
            vx[1] = $signed(w.bx);
            vy[1] = $signed(w.by);
            vx[2] = $signed(w.cx);
            vy[2] = $signed(w.cy);
            // Three compare-and-swap stages, in the same order as the front end.
            if (vy[0] > vy[1]) swap_vertex(0, 1);
            if (vy[0] > vy[2]) swap_vertex(0, 2);
            if (vy[1] > vy[2]) swap_vertex(1, 2);
            lvl = (w.light > LIGHT_FULL) ? int'(LIGHT_FULL) : int'(w.light);
            fill[0] = lit_on ? 8'((int'(w.red) * lvl) >> 8) : w.red;
            fill[1] = lit_on ? 8'((int'(w.green) * lvl) >> 8) : w.green;
            fill[2] = lit_on ? 8'((int'(w.blue) * lvl) >> 8) : w.blue;
            fill[3] = w.alpha;
            row_idx = 0;
            tri_live = (vy[2] - vy[0]) > 0;
            return 1'b0;
        end
        if (!tri_live)
            return 1'b0;
        total = vy[2] - vy[0];
        upper = vy[1] - vy[0];
        i = row_idx;
        if (i >= total)
        begin
            tri_live = 1'b0;
            return 1'b0;
        end
        // The long edge runs top to bottom; the short edge switches to the
        // lower segment past the middle vertex.
        lower = (i > upper) || (upper == 0);
        seg = lower ? (vy[2] - vy[1]) : upper;
        off = lower ? upper : 0;
        ax = vx[0] + (i * (vx[2] - vx[0])) / total;
        if (seg > 0)
        begin
            if (lower)
                bx = vx[1] + ((i - off) * (vx[2] - vx[1])) / seg;
            else
                bx = vx[0] + ((i - off) * (vx[1] - vx[0])) / seg;
        end
        else
        begin
            bx = lower ? vx[1] : vx[0];
        end
        s = span_of(vy[0] + i, (ax < bx) ? ax : bx, (ax < bx) ? bx : ax,
                    fill[0], fill[1], fill[2], fill[3], i == total - 1);
        row_idx = i + 1;
        if (i + 1 >= total)
            tri_live = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_x();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return -2048;
        if (r < 10)
            return 2047;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int pick_light();
        if ($urandom_range(99) < 60)
            return $urandom_range(256);
        return $urandom_range(511);
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Drives one word, waits until it is taken and queues its expected span.
    task automatic send_word(input tri_word_t w, input check_kind_t kind,
                             input span_t want, output bit spanned);
        span_t s;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= w.cmd;
        first_x <= w.ax;
        first_y <= w.ay;
        second_x <= w.bx;
        second_y <= w.by;
        third_x <= w.cx;
        third_y <= w.cy;
        red <= w.red;
        green <= w.green;
        blue <= w.blue;
        alpha <= w.alpha;
        light_level <= w.light;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        spanned = raster_word(w, s);
        if (w.cmd == CMD_LOAD)
            n_loads++;
        else
            n_steps++;
        if (kind == CHK_MODEL && spanned)
            spans_due.insert(spans_due.size(), s);
        else if (kind == CHK_SPAN)
            spans_due.insert(spans_due.size(), want);
    endtask

    // Lets the block drain, then sets the lighting switch and the idling mode.
    task automatic start_phase(input bit light_on, input bit idling);
        @(negedge clk);
        in_valid <= 1'b0;
        while (spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        gaps_on = idling;
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= light_on;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        lit_on = light_on;
        n_cfg++;
    endtask

    // Mostly whole triangles stepped to their last row, some cut short by a
    // reload, plus random loads of any height and stray steps. The target
    // counts input words.
    task automatic random_phase(input int target);
        int made, pick, h, top, k, j, t, steps;
        int ys [3];
        bit spanned;
        tri_word_t w;
        made = 0;
        while (made < target)
        begin
            pick = $urandom_range(99);
            steps = 1;
            if (pick < 90)
            begin
                if (pick < 80)
                begin
                    t = $urandom_range(99);
                    h = (t < 3) ? $urandom_range(120, 41) :
                        (t < 10) ? $urandom_range(40, 11) : $urandom_range(10);
                    top = int'($urandom_range(4095 - h)) - 2048;
                    ys[0] = top;
                    ys[1] = top + $urandom_range(h);
                    ys[2] = top + h;
                    for (k = 2; k > 0; k--)
                    begin
                        j = $urandom_range(k);
                        t = ys[k];
                        ys[k] = ys[j];
                        ys[j] = t;
                    end
                    w = tri_load(pick_x(), ys[0], pick_x(), ys[1], pick_x(), ys[2],
                                 $urandom, $urandom, $urandom, $urandom, pick_light());
                    if (h == 0)
                        steps = $urandom_range(2);
                    else if ($urandom_range(9) == 0)
                        steps = $urandom_range(h - 1);
                    else
                        steps = h + $urandom_range(2);
                end
                else
                begin
                    w = tri_load($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
                    steps = $urandom_range(3);
                end
                send_word(w, CHK_MODEL, '0, spanned);
                made++;
            end
            repeat (steps)
            begin
                send_word(step_word(), CHK_MODEL, '0, spanned);
                made++;
            end
        end
    endtask

    // Idle-cycle watchdog on both channels.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word taken for %0d cycles", WATCHDOG_LIMIT);
            $display("triangle_scanline_span_generator: mismatch");
            $finish;
        end
    end

    // Output stall, applied at random while idling is on.
    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(99) < 16);
    end

    // Compares each taken span with the oldest expected one.
    always @(posedge clk)
    begin : span_check
        span_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = span_of(row_y, span_left, span_right, out_red, out_green,
                          out_blue, out_alpha, last_row);
            if (spans_due.size() == 0)
            begin
                report($sformatf("unexpected span: %s", span_text(got)));
            end
            else
            begin
                want = spans_due.pop_front();
                n_checked++;
                if (got.row !== want.row || got.lo_x !== want.lo_x ||
                    got.hi_x !== want.hi_x || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.alpha !== want.alpha || got.last !== want.last)
                    report($sformatf("expected %s, got %s", span_text(want),
                                     span_text(got)));
            end
        end
    end

    initial
    begin
        bit spanned;
        int n;
        // Lighting off: nothing pending, zero height, rows at both y extremes
        // with x at both extremes, then a two-segment triangle.
        add_row('{1'b0, step_word(), CHK_NONE, '0});
        add_row('{1'b0, tri_load(3, 5, -7, 5, 9, 5, 1, 2, 3, 4, 256), CHK_NONE, '0});
        add_row('{1'b0, step_word(), CHK_NONE, '0});
        add_row('{1'b0, tri_load(-2048, 2047, 2047, 2046, -2048, 2046,
                                 255, 0, 255, 0, 0), CHK_NONE, '0});
        add_row('{1'b0, step_word(), CHK_SPAN,
                  span_of(2046, -2048, 2047, 255, 0, 255, 0, 1'b1)});
        add_row('{1'b0, step_word(), CHK_NONE, '0});
        add_row('{1'b0, tri_load(0, -2048, 2047, -2047, -2048, -2048,
                                 0, 255, 0, 255, 511), CHK_NONE, '0});
        add_row('{1'b0, step_word(), CHK_SPAN,
                  span_of(-2048, -2048, 0, 0, 255, 0, 255, 1'b1)});
        add_row('{1'b0, tri_load(10, 0, -5, 3, 20, 6, 17, 34, 51, 68, 100),
                  CHK_NONE, '0});
        repeat (7) add_row('{1'b0, step_word(), CHK_MODEL, '0});
        // Lighting on: light above full, zero light, half light.
        add_row('{1'b1, tri_load(0, 0, 8, 4, -8, 2, 200, 100, 50, 7, 511),
                  CHK_NONE, '0});
        add_row('{1'b1, step_word(), CHK_SPAN,
                  span_of(0, 0, 0, 200, 100, 50, 7, 1'b0)});
        repeat (3) add_row('{1'b1, step_word(), CHK_MODEL, '0});
        add_row('{1'b1, tri_load(5, -3, 5, -3, 9, -2, 255, 255, 255, 255, 0),
                  CHK_NONE, '0});
        add_row('{1'b1, step_word(), CHK_SPAN,
                  span_of(-3, 5, 5, 0, 0, 0, 255, 1'b1)});
        add_row('{1'b1, tri_load(-10, 100, 10, 100, 0, 103, 255, 1, 128, 64, 128),
                  CHK_NONE, '0});
        add_row('{1'b1, step_word(), CHK_MODEL, '0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < dir_rows.size(); n++)
        begin
            if (dir_rows[n].lit != lit_on)
                start_phase(dir_rows[n].lit, 1'b1);
            send_word(dir_rows[n].w, dir_rows[n].kind, dir_rows[n].want, spanned);
        end

        start_phase(1'b0, 1'b1);
        random_phase(160);
        start_phase(1'b1, 1'b1);
        random_phase(160);
        // A long stretch with no idling on either side.
        start_phase(1'b0, 1'b0);
        random_phase(140);
        start_phase(1'b1, 1'b1);
        random_phase(150);

        @(negedge clk);
        in_valid <= 1'b0;
        while (spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d triangle loads and %0d step words; %0d spans compared.",
                 n_loads, n_steps, n_checked);
        $display("Lighting switched %0d times, with and without back-pressure.", n_cfg);
        if (errors == 0)
            $display("triangle_scanline_span_generator: match");
        else
            $display("triangle_scanline_span_generator: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tssg_pkg.sv
hw/rtl/tssg_front.sv
hw/rtl/tssg_queue.sv
hw/rtl/tssg_div.sv
hw/rtl/tssg_back.sv
hw/rtl/triangle_scanline_span_generator.sv
verif/tb_top.sv
